/* hdl/byte_memory_register_vm_core_assert.svh */
// Assertion macros for the byte memory register interpreter core
`ifndef BYTE_MEMORY_REGISTER_VM_CORE_ASSERT_SVH
`define BYTE_MEMORY_REGISTER_VM_CORE_ASSERT_SVH
`ifndef SYNTH
`define BMVM_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define BMVM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define BMVM_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define BMVM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

/* hdl/bmvm_pkg.sv */
// Shared types and constants of the byte memory register interpreter core
`default_nettype none
package bmvm_pkg;
  localparam int unsigned InstrBytes = 12;
  localparam logic [7:0] OpLast = 8'd24;

  typedef enum logic [1:0] {
    FUNC_WRITE = 2'd0, FUNC_READ = 2'd1, FUNC_EXEC = 2'd2, FUNC_RESTART = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ST_RUN = 3'd0, ST_HALT = 3'd1, ST_BADOP = 3'd2, ST_BADREG = 3'd3,
    ST_BADADDR = 3'd4, ST_DIVZERO = 3'd5
  } status_t;

  typedef enum logic [4:0] {
    OP_LDB = 5'd0, OP_LDBI = 5'd1, OP_LDR = 5'd2, OP_LDRI = 5'd3, OP_ADD = 5'd4,
    OP_SUB = 5'd5, OP_MUL = 5'd6, OP_DIV = 5'd7, OP_TRP = 5'd8, OP_STB = 5'd9,
    OP_STBI = 5'd10, OP_STR = 5'd11, OP_STRI = 5'd12, OP_JMP = 5'd13,
    OP_JMR = 5'd14, OP_BNZ = 5'd15, OP_BGT = 5'd16, OP_BLT = 5'd17,
    OP_BRZ = 5'd18, OP_MOV = 5'd19, OP_LDA = 5'd20, OP_ADI = 5'd21,
    OP_AND = 5'd22, OP_OR = 5'd23, OP_CMP = 5'd24, OP_NONE = 5'd31
  } opcode_t;

  typedef enum logic [3:0] {
    S_IDLE, S_MEMOP, S_MEMWAIT, S_FETCH, S_DECODE, S_DATA, S_STORE, S_DIV,
    S_COMMIT, S_OUT
  } state_t;

  // Handshake between the sequencer and the divider
  typedef struct packed {
    logic start;
    logic busy;
  } div_ctl_t;

  // Trap codes
  localparam logic [31:0] TrapHalt = 32'd0;
  localparam logic [31:0] TrapInt = 32'd1;
  localparam logic [31:0] TrapChar = 32'd3;

  function automatic logic uses_reg1(input logic [7:0] op);
    return !(op == 8'(OP_TRP) || op == 8'(OP_JMP));
  endfunction

  function automatic logic uses_reg2(input logic [7:0] op);
    case (op)
      8'(OP_LDBI), 8'(OP_LDRI), 8'(OP_ADD), 8'(OP_SUB), 8'(OP_MUL), 8'(OP_DIV),
      8'(OP_STBI), 8'(OP_STRI), 8'(OP_MOV), 8'(OP_AND), 8'(OP_OR),
      8'(OP_CMP): return 1'b1;
      default: return 1'b0;
    endcase
  endfunction
endpackage
`default_nettype wire

/* hdl/bmvm_div.sv */
// Restoring divider, one quotient bit per cycle, signed 32-bit
`default_nettype none
module bmvm_div (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  input  wire logic [31:0]     dividend,
  input  wire logic [31:0]     divisor,
  output bmvm_pkg::div_ctl_t   ctl,
  output logic      [31:0]     quotient
);
  import bmvm_pkg::*;

  logic        busy_r, busy_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [31:0] rem_r, rem_nxt, quo_r, quo_nxt, den_r, den_nxt;
  logic        neg_r, neg_nxt;
  logic [32:0] trial;

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    den_nxt  = den_r;
    neg_nxt  = neg_r;
    trial    = {rem_r, quo_r[31]} - {1'b0, den_r};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 6'd32;
      rem_nxt  = '0;
      quo_nxt  = dividend[31] ? 32'd0 - dividend : dividend;
      den_nxt  = divisor[31] ? 32'd0 - divisor : divisor;
      neg_nxt  = dividend[31] ^ divisor[31];
    end else if (busy_r) begin
      // shift one bit in, subtract when it fits
      if (!trial[32]) begin
        rem_nxt = trial[31:0];
        quo_nxt = {quo_r[30:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[30:0], quo_r[31]};
        quo_nxt = {quo_r[30:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
    neg_r <= neg_nxt;
  end

  assign ctl.start = start;
  assign ctl.busy  = busy_r;
  assign quotient  = neg_r ? 32'd0 - quo_r : quo_r;
endmodule
`default_nettype wire

/* hdl/bmvm_mem.sv */
// Byte memory, one port, registered read
`default_nettype none
module bmvm_mem #(
  parameter int unsigned MEM_BYTES = 65536,
  parameter int unsigned AW = $clog2(MEM_BYTES)
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] addr,
  input  wire logic [7:0]    wdata,
  output logic      [7:0]    rdata
);
  logic [7:0] mem [MEM_BYTES];

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

/* hdl/byte_memory_register_vm_core.sv */
// Top level of the byte memory register interpreter core
`default_nettype none
// Interpreter core over a single-port byte memory and a small register file.
// A memory write or read item passes the memory-op and memory-wait states,
// and a restart goes from idle straight to the output state. An executed
// instruction passes idle, is fetched one byte at a time, then passes
// decode, commit and the output state. A load adds data-byte reads on the
// memory port, a store adds data-byte writes, and a divide waits in the
// divide state until the divider is done. A fault found at decode, and an
// execute item while halted or with the program counter beyond memory, go
// straight to the output state. The memory port serializes accesses. One item
// is processed at a time: in_stall stays high until the result register has
// been loaded, and a stalled result holds the sequencer in its output state.
// start_address is written over the APB port at byte address 0.
module byte_memory_register_vm_core #(
  parameter int unsigned MEM_BYTES = 65536,
  parameter int unsigned NUM_REGS  = 10
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_func,
  input  wire logic [15:0] in_mem_address,
  input  wire logic [7:0]  in_write_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic      [7:0]  out_read_byte,
  output logic      [15:0] out_program_counter,
  output logic             out_trap_valid,
  output logic             out_trap_kind,
  output logic signed [31:0] out_trap_value,
  output logic      [2:0]  out_run_status,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [1:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic      [31:0] cfg_prdata,
  output logic             cfg_pready
);
  import bmvm_pkg::*;
  `include "byte_memory_register_vm_core_assert.svh"

  localparam int unsigned AW = $clog2(MEM_BYTES);
  localparam int unsigned RW = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;

  // Configuration
  logic [15:0] start_r;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == 2'd0) ? {16'd0, start_r} : 32'd0;
  always_ff @(posedge clk) begin
    if (!rst_n) start_r <= '0;
    else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == 2'd0)
      start_r <= cfg_pwdata[15:0];
  end

  // Architectural state and sequencer registers
  state_t      st_r, st_nxt;
  logic [31:0] regs_r [NUM_REGS];
  logic [15:0] pc_r, pc_nxt;
  status_t     stat_r, stat_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic [7:0]  ibuf_r [InstrBytes];
  logic [31:0] dbuf_r, dbuf_nxt;
  logic [31:0] addr_r, addr_nxt;
  logic [2:0]  nbytes_r, nbytes_nxt;
  logic        inreq_r, inreq_nxt;
  logic [1:0]  func_r;
  logic [15:0] maddr_r;
  logic [7:0]  wbyte_r;
  logic [31:0] wres_r, wres_nxt;
  logic        wen_r, wen_nxt;
  logic        ov_r;
  logic [7:0]  orb_r, orb_nxt;
  logic        otv_r, otv_nxt, otk_r, otk_nxt;
  logic [31:0] otval_r, otval_nxt;

  // Memory port
  logic          mwe;
  logic [AW-1:0] maddr;
  logic [7:0]    mwdata, mrdata;
  bmvm_mem #(.MEM_BYTES(MEM_BYTES)) u_mem (
    .clk(clk), .we(mwe), .addr(maddr), .wdata(mwdata), .rdata(mrdata)
  );

  // Divider
  div_ctl_t    dctl;
  logic        dstart;
  logic [31:0] quo;

  // Decoded instruction
  logic [7:0]  op;
  logic [31:0] o1, o2, a, b;
  logic [RW-1:0] r1, r2;
  assign op = ibuf_r[0];
  assign o1 = {ibuf_r[7], ibuf_r[6], ibuf_r[5], ibuf_r[4]};
  assign o2 = {ibuf_r[11], ibuf_r[10], ibuf_r[9], ibuf_r[8]};
  assign r1 = o1[RW-1:0];
  assign r2 = o2[RW-1:0];
  assign a = (uses_reg1(op) && o1 < 32'(NUM_REGS)) ? regs_r[r1] : 32'd0;
  assign b = (uses_reg2(op) && o2 < 32'(NUM_REGS)) ? regs_r[r2] : 32'd0;

  bmvm_div u_div (
    .clk(clk), .rst_n(rst_n), .start(dstart), .dividend(a), .divisor(b),
    .ctl(dctl), .quotient(quo)
  );

  logic        ok_pc, take;
  logic [31:0] daddr, target;
  logic [32:0] pc_end;
  assign pc_end = 33'(pc_r) + 33'(InstrBytes);
  assign ok_pc  = pc_end <= 33'(MEM_BYTES);

  // Data address and branch decision
  always_comb begin
    daddr = o2;
    if (op == 8'(OP_LDBI) || op == 8'(OP_LDRI) || op == 8'(OP_STBI) ||
        op == 8'(OP_STRI)) daddr = b;
    take   = 1'b0;
    target = o2;
    case (op)
      8'(OP_JMP): begin take = 1'b1; target = o1; end
      8'(OP_JMR): begin take = 1'b1; target = a; end
      8'(OP_BNZ): take = a != 32'd0;
      8'(OP_BGT): take = !a[31] && a != 32'd0;
      8'(OP_BLT): take = a[31];
      8'(OP_BRZ): take = a == 32'd0;
      default: take = 1'b0;
    endcase
  end

  logic [15:0] pc_seq;
  logic [31:0] mem_idx;
  logic [33:0] dspan;
  assign pc_seq  = 16'(pc_end);
  assign mem_idx = addr_r + 32'(cnt_r);
  assign dspan   = 34'(daddr) + 34'(nbytes_r);

  // Sequencer
  always_comb begin
    st_nxt     = st_r;
    pc_nxt     = pc_r;
    stat_nxt   = stat_r;
    cnt_nxt    = cnt_r;
    dbuf_nxt   = dbuf_r;
    addr_nxt   = addr_r;
    nbytes_nxt = nbytes_r;
    inreq_nxt  = inreq_r;
    wres_nxt   = wres_r;
    wen_nxt    = 1'b0;
    orb_nxt    = orb_r;
    otv_nxt    = otv_r;
    otk_nxt    = otk_r;
    otval_nxt  = otval_r;
    mwe        = 1'b0;
    maddr      = mem_idx[AW-1:0];
    mwdata     = dbuf_r[7:0];
    dstart     = 1'b0;
    unique case (st_r)
      S_IDLE: begin
        if (inreq_r) begin
          inreq_nxt = 1'b0;
          orb_nxt = '0; otv_nxt = 1'b0; otk_nxt = 1'b0; otval_nxt = '0;
          unique case (func_t'(func_r))
            FUNC_WRITE, FUNC_READ: st_nxt = S_MEMOP;
            FUNC_EXEC: begin
              if (stat_r != ST_RUN) st_nxt = S_OUT;
              else if (!ok_pc) begin stat_nxt = ST_BADADDR; st_nxt = S_OUT; end
              else begin
                addr_nxt = 32'(pc_r);
                cnt_nxt  = '0;
                st_nxt   = S_FETCH;
              end
            end
            default: begin
              pc_nxt = start_r; stat_nxt = ST_RUN; st_nxt = S_OUT;
            end
          endcase
        end
      end
      S_MEMOP: begin
        maddr = AW'(maddr_r);
        mwdata = wbyte_r;
        mwe = (func_r == FUNC_WRITE) && 32'(maddr_r) < 32'(MEM_BYTES);
        st_nxt = S_MEMWAIT;
      end
      S_MEMWAIT: begin
        if (func_r == FUNC_READ && 32'(maddr_r) < 32'(MEM_BYTES)) orb_nxt = mrdata;
        st_nxt = S_OUT;
      end
      // one byte per cycle; data of the previous address arrives now
      S_FETCH: begin
        cnt_nxt = cnt_r + 4'd1;
        if (cnt_r == 4'(InstrBytes)) st_nxt = S_DECODE;
      end
      S_DECODE: begin
        nbytes_nxt = (op == 8'(OP_LDR) || op == 8'(OP_LDRI) || op == 8'(OP_STR) ||
                      op == 8'(OP_STRI)) ? 3'd4 : 3'd1;
        st_nxt = S_OUT;
        if (op > OpLast) stat_nxt = ST_BADOP;
        else if ((uses_reg1(op) && o1 >= 32'(NUM_REGS)) ||
                 (uses_reg2(op) && o2 >= 32'(NUM_REGS))) stat_nxt = ST_BADREG;
        else st_nxt = S_COMMIT;
      end
      S_COMMIT: begin
        st_nxt = S_OUT;
        pc_nxt = pc_seq;
        case (op)
          8'(OP_LDB), 8'(OP_LDBI), 8'(OP_LDR), 8'(OP_LDRI), 8'(OP_STB),
          8'(OP_STBI), 8'(OP_STR), 8'(OP_STRI): begin
            if (dspan > 34'(MEM_BYTES)) begin
              stat_nxt = ST_BADADDR; pc_nxt = pc_r;
            end else begin
              addr_nxt = daddr;
              cnt_nxt = '0;
              dbuf_nxt = a;
              pc_nxt = pc_r;
              st_nxt = (op == 8'(OP_STB) || op == 8'(OP_STBI) || op == 8'(OP_STR) ||
                        op == 8'(OP_STRI)) ? S_STORE : S_DATA;
            end
          end
          8'(OP_ADD): begin wres_nxt = a + b; wen_nxt = 1'b1; end
          8'(OP_SUB): begin wres_nxt = a - b; wen_nxt = 1'b1; end
          8'(OP_MUL): begin wres_nxt = a * b; wen_nxt = 1'b1; end
          8'(OP_DIV): begin
            pc_nxt = pc_r;
            if (b == 32'd0) stat_nxt = ST_DIVZERO;
            else begin dstart = 1'b1; st_nxt = S_DIV; end
          end
          8'(OP_TRP): begin
            if (o1 == TrapHalt) stat_nxt = ST_HALT;
            else if (o1 == TrapInt || o1 == TrapChar) begin
              otv_nxt = 1'b1; otk_nxt = (o1 == TrapChar); otval_nxt = regs_r[0];
            end
          end
          8'(OP_JMP), 8'(OP_JMR), 8'(OP_BNZ), 8'(OP_BGT), 8'(OP_BLT),
          8'(OP_BRZ): begin
            if (take) begin
              if (target > 32'h0000_FFFF) begin stat_nxt = ST_BADADDR; pc_nxt = pc_r; end
              else pc_nxt = target[15:0];
            end
          end
          8'(OP_MOV): begin wres_nxt = b; wen_nxt = 1'b1; end
          8'(OP_LDA): begin wres_nxt = o2; wen_nxt = 1'b1; end
          8'(OP_ADI): begin wres_nxt = a + o2; wen_nxt = 1'b1; end
          8'(OP_AND): begin wres_nxt = {31'd0, a == 32'd1 && b == 32'd1}; wen_nxt = 1'b1; end
          8'(OP_OR): begin wres_nxt = {31'd0, !(a == 32'd0 && b == 32'd0)}; wen_nxt = 1'b1; end
          default: begin
            wres_nxt = (a == b) ? 32'd0 : ($signed(a) > $signed(b)) ? 32'd1 : 32'hFFFF_FFFF;
            wen_nxt = 1'b1;
          end
        endcase
      end
      // load: read bytes little-endian, one a cycle
      S_DATA: begin
        cnt_nxt = cnt_r + 4'd1;
        if (cnt_r != 4'd0)
          dbuf_nxt = (nbytes_r == 3'd1) ? {24'd0, mrdata} : {mrdata, dbuf_r[31:8]};
        if (cnt_r == 4'(nbytes_r)) begin
          wres_nxt = dbuf_nxt; wen_nxt = 1'b1; pc_nxt = pc_seq; st_nxt = S_OUT;
        end
      end
      S_STORE: begin
        mwe = 1'b1;
        dbuf_nxt = {8'd0, dbuf_r[31:8]};
        cnt_nxt = cnt_r + 4'd1;
        if (cnt_r == 4'(nbytes_r) - 4'd1) begin pc_nxt = pc_seq; st_nxt = S_OUT; end
      end
      S_DIV: begin
        if (!dctl.busy) begin
          wres_nxt = quo; wen_nxt = 1'b1; pc_nxt = pc_seq; st_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!ov_r || !out_stall) st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  logic in_acc, out_acc;
  assign in_acc   = in_valid && !in_stall;
  assign out_acc  = ov_r && !out_stall;
  assign in_stall = inreq_r || st_r != S_IDLE;

  // Instruction byte capture: byte cnt-1 arrives while cnt counts
  always_ff @(posedge clk) begin
    if (st_r == S_FETCH && cnt_r != 4'd0) ibuf_r[cnt_r - 4'd1] <= mrdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= S_IDLE;
      pc_r    <= '0;
      stat_r  <= ST_HALT;
      inreq_r <= 1'b0;
      ov_r    <= 1'b0;
      wen_r   <= 1'b0;
      for (int i = 0; i < NUM_REGS; i++) regs_r[i] <= '0;
    end else begin
      st_r   <= st_nxt;
      pc_r   <= pc_nxt;
      stat_r <= stat_nxt;
      wen_r  <= wen_nxt;
      inreq_r <= in_acc ? 1'b1 : inreq_nxt;
      if (wen_r) regs_r[r1] <= wres_r;
      if (st_r == S_OUT && (!ov_r || !out_stall)) ov_r <= 1'b1;
      else if (out_acc) ov_r <= 1'b0;
    end
    cnt_r    <= cnt_nxt;
    dbuf_r   <= dbuf_nxt;
    addr_r   <= addr_nxt;
    nbytes_r <= nbytes_nxt;
    wres_r   <= wres_nxt;
    orb_r    <= orb_nxt;
    otv_r    <= otv_nxt;
    otk_r    <= otk_nxt;
    otval_r  <= otval_nxt;
    if (in_acc) begin
      func_r  <= in_func;
      maddr_r <= in_mem_address;
      wbyte_r <= in_write_byte;
    end
  end

  // Result register, loaded when leaving the output state
  always_ff @(posedge clk) begin
    if (st_r == S_OUT && (!ov_r || !out_stall)) begin
      out_read_byte       <= orb_r;
      out_program_counter <= pc_r;
      out_trap_valid      <= otv_r;
      out_trap_kind       <= otk_r;
      out_trap_value      <= otval_r;
      out_run_status      <= stat_r;
    end
  end
  assign out_valid = ov_r;

  `BMVM_ASSERT_IMPL(a_no_accept_busy, clk, rst_n, st_r != S_IDLE, in_stall,
    "input accepted while busy")
  `BMVM_ASSERT_IMPL(a_div_only_in_div, clk, rst_n, dctl.busy,
    st_r == S_DIV, "divider busy outside divide state")
  `BMVM_ASSERT_NEXT(a_trap_needs_run, clk, rst_n, st_r == S_COMMIT && otv_nxt,
    stat_r == ST_RUN, "print trap while not running")
endmodule
`default_nettype wire

/* verif/tb_top.sv */
// Self-checking testbench for the byte memory register interpreter core
`timescale 1ns / 1ps

import bmvm_pkg::*;

typedef struct {
  bit [7:0]  read_byte;
  bit [15:0] pc;
  bit        trap_valid;
  bit        trap_kind;
  bit [31:0] trap_value;
  bit [2:0]  status;
} vm_result_t;

// Shadow interpreter and queue of predicted results
class vm_scoreboard;
  bit [7:0]    mem [65536];
  bit          known [65536];
  int unsigned known_q[$];
  bit [31:0]   regs [10];
  bit [15:0]   pc;
  status_t     st;
  bit [15:0]   start_addr;
  vm_result_t  pending_q[$];
  int unsigned errors, n_exec, n_traps, n_faults, n_checked;

  function new();
    st = ST_HALT;
  endfunction

  function void poke(bit [31:0] a, bit [7:0] v);
    mem[a] = v;
    if (!known[a]) begin
      known[a] = 1'b1;
      known_q.push_back(a);
    end
  endfunction

  function bit [31:0] peek32(bit [31:0] a);
    return {mem[a + 3], mem[a + 2], mem[a + 1], mem[a]};
  endfunction

  function bit fits(bit [31:0] a, int unsigned n);
    return (64'(a) + n) <= 64'd65536;
  endfunction

  function bit reg1_used(bit [7:0] op);
    return op != 8'(OP_TRP) && op != 8'(OP_JMP);
  endfunction

  function bit reg2_used(bit [7:0] op);
    case (op)
      8'(OP_LDBI), 8'(OP_LDRI), 8'(OP_ADD), 8'(OP_SUB), 8'(OP_MUL), 8'(OP_DIV),
      8'(OP_STBI), 8'(OP_STRI), 8'(OP_MOV), 8'(OP_AND), 8'(OP_OR),
      8'(OP_CMP): return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  // True when all 12 bytes at the PC are known (or the fetch faults anyway)
  function bit instr_ready();
    if (!fits(pc, InstrBytes)) return 1'b1;
    for (int i = 0; i < InstrBytes; i++)
      if (!known[pc + i]) return 1'b0;
    return 1'b1;
  endfunction

  // Unknown data bytes that the instruction at the PC would load
  function void data_needs(ref int unsigned need_q[$]);
    bit [7:0]  op;
    bit [31:0] o1, o2, addr;
    int unsigned n;
    need_q.delete();
    if (!fits(pc, InstrBytes)) return;
    op = mem[pc];
    o1 = peek32(pc + 4);
    o2 = peek32(pc + 8);
    if (op > OpLast) return;
    if (reg1_used(op) && o1 >= 10) return;
    if (reg2_used(op) && o2 >= 10) return;
    case (op)
      8'(OP_LDB), 8'(OP_LDBI): n = 1;
      8'(OP_LDR), 8'(OP_LDRI): n = 4;
      default: return;
    endcase
    addr = (op == 8'(OP_LDB) || op == 8'(OP_LDR)) ? o2 : regs[o2];
    if (!fits(addr, n)) return;
    for (int i = 0; i < n; i++)
      if (!known[addr + i]) need_q.push_back(addr + i);
  endfunction

  function void step_instr(ref vm_result_t r);
    bit [7:0]  op;
    bit [31:0] o1, o2, a, b, addr, target, nxt, ma, mb, q;
    bit        take;
    n_exec++;
    if (!fits(pc, InstrBytes)) begin st = ST_BADADDR; n_faults++; return; end
    op = mem[pc];
    o1 = peek32(pc + 4);
    o2 = peek32(pc + 8);
    if (op > OpLast) begin st = ST_BADOP; n_faults++; return; end
    if ((reg1_used(op) && o1 >= 10) || (reg2_used(op) && o2 >= 10)) begin
      st = ST_BADREG; n_faults++; return;
    end
    nxt = (32'(pc) + InstrBytes) & 32'hFFFF;
    a = reg1_used(op) ? regs[o1] : 32'd0;
    b = reg2_used(op) ? regs[o2] : 32'd0;
    case (op)
      8'(OP_LDB), 8'(OP_LDBI): begin
        addr = (op == 8'(OP_LDB)) ? o2 : b;
        if (!fits(addr, 1)) begin st = ST_BADADDR; n_faults++; return; end
        regs[o1] = {24'd0, mem[addr]};
      end
      8'(OP_LDR), 8'(OP_LDRI): begin
        addr = (op == 8'(OP_LDR)) ? o2 : b;
        if (!fits(addr, 4)) begin st = ST_BADADDR; n_faults++; return; end
        regs[o1] = peek32(addr);
      end
      8'(OP_ADD): regs[o1] = a + b;
      8'(OP_SUB): regs[o1] = a - b;
      8'(OP_MUL): regs[o1] = a * b;
      8'(OP_DIV): begin
        if (b == 0) begin st = ST_DIVZERO; n_faults++; return; end
        ma = a[31] ? -a : a;
        mb = b[31] ? -b : b;
        q = ma / mb;
        regs[o1] = (a[31] != b[31]) ? -q : q;
      end
      8'(OP_TRP): begin
        if (o1 == TrapHalt) st = ST_HALT;
        else if (o1 == TrapInt || o1 == TrapChar) begin
          r.trap_valid = 1'b1;
          r.trap_kind = (o1 == TrapChar);
          r.trap_value = regs[0];
          n_traps++;
        end
      end
      8'(OP_STB), 8'(OP_STBI): begin
        addr = (op == 8'(OP_STB)) ? o2 : b;
        if (!fits(addr, 1)) begin st = ST_BADADDR; n_faults++; return; end
        poke(addr, a[7:0]);
      end
      8'(OP_STR), 8'(OP_STRI): begin
        addr = (op == 8'(OP_STR)) ? o2 : b;
        if (!fits(addr, 4)) begin st = ST_BADADDR; n_faults++; return; end
        for (int i = 0; i < 4; i++) poke(addr + i, a[8*i +: 8]);
      end
      8'(OP_JMP), 8'(OP_JMR), 8'(OP_BNZ), 8'(OP_BGT), 8'(OP_BLT), 8'(OP_BRZ): begin
        target = o2;
        case (op)
          8'(OP_JMP): begin take = 1'b1; target = o1; end
          8'(OP_JMR): begin take = 1'b1; target = a; end
          8'(OP_BNZ): take = $signed(a) != 0;
          8'(OP_BGT): take = $signed(a) > 0;
          8'(OP_BLT): take = $signed(a) < 0;
          default:    take = $signed(a) == 0;
        endcase
        if (take) begin
          if (target > 32'hFFFF) begin st = ST_BADADDR; n_faults++; return; end
          nxt = target;
        end
      end
      8'(OP_MOV): regs[o1] = b;
      8'(OP_LDA): regs[o1] = o2;
      8'(OP_ADI): regs[o1] = a + o2;
      8'(OP_AND): regs[o1] = (a == 1 && b == 1) ? 32'd1 : 32'd0;
      8'(OP_OR):  regs[o1] = (a == 0 && b == 0) ? 32'd0 : 32'd1;
      default:
        regs[o1] = ($signed(a) == $signed(b)) ? 32'd0 :
                   ($signed(a) > $signed(b)) ? 32'd1 : 32'hFFFF_FFFF;
    endcase
    pc = nxt[15:0];
  endfunction

  // Accepted input transaction: update the shadow state, queue the result
  function void note(func_t f, bit [15:0] a, bit [7:0] d);
    vm_result_t r;
    r = '{default: 0};
    case (f)
      FUNC_WRITE: poke(a, d);
      FUNC_READ:  r.read_byte = mem[a];
      FUNC_EXEC:  if (st == ST_RUN) step_instr(r);
      default: begin
        pc = start_addr;
        st = ST_RUN;
      end
    endcase
    r.pc = pc;
    r.status = st;
    pending_q.push_back(r);
  endfunction

  function void check(vm_result_t got);
    vm_result_t want;
    if (pending_q.size() == 0) begin
      $error("result transaction with nothing expected");
      errors++;
      return;
    end
    want = pending_q.pop_front();
    n_checked++;
    if (got.read_byte != want.read_byte) begin
      $error("read_byte: expected %0h, got %0h", want.read_byte, got.read_byte); errors++;
    end
    if (got.pc != want.pc) begin
      $error("program_counter: expected %0h, got %0h", want.pc, got.pc); errors++;
    end
    if (got.trap_valid != want.trap_valid) begin
      $error("trap_valid: expected %0d, got %0d", want.trap_valid, got.trap_valid); errors++;
    end
    if (got.trap_kind != want.trap_kind) begin
      $error("trap_kind: expected %0d, got %0d", want.trap_kind, got.trap_kind); errors++;
    end
    if (got.trap_value != want.trap_value) begin
      $error("trap_value: expected %0h, got %0h", want.trap_value, got.trap_value); errors++;
    end
    if (got.status != want.status) begin
      $error("run_status: expected %0d, got %0d", want.status, got.status); errors++;
    end
  endfunction
endclass

module tb_top;
  localparam int QUIET_LIMIT = 20000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_func = 2'd0;
  logic [15:0] in_mem_address = 16'd0;
  logic [7:0]  in_write_byte = 8'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_read_byte;
  logic [15:0] out_program_counter;
  logic        out_trap_valid;
  logic        out_trap_kind;
  logic signed [31:0] out_trap_value;
  logic [2:0]  out_run_status;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [1:0]  cfg_paddr = 2'd0;
  logic [31:0] cfg_pwdata = 32'd0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  vm_scoreboard vm = new();
  int unsigned  idle_pct = 0, stall_pct = 0, n_items = 0, quiet = 0;
  int unsigned  need_q[$];

  byte_memory_register_vm_core dut (.*);

  initial begin
    forever #4 clk = ~clk;
  end

  // Receiver stalls
  always @(posedge clk) out_stall <= ($urandom_range(0, 99) < stall_pct);

  // Result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      vm.check('{out_read_byte, out_program_counter, out_trap_valid, out_trap_kind,
                 out_trap_value, out_run_status});
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", QUIET_LIMIT);
      $display("** byte_memory_register_vm_core: FAILED **");
      $finish;
    end
  end

  task automatic send(func_t f, bit [15:0] a, bit [7:0] d);
    if ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_func <= f;
    in_mem_address <= a;
    in_write_byte <= d;
    do @(posedge clk); while (in_stall);
    vm.note(f, a, d);
    n_items++;
  endtask

  // Drain every pending result, then let the core settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (vm.pending_q.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic set_start(bit [15:0] v);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= 2'd0;
    cfg_pwdata <= {16'd0, v};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    vm.start_addr = v;
  endtask

  // Lay an instruction down at the PC; the upper opcode bytes are junk
  task automatic put_instr(bit [7:0] op, bit [31:0] o1, bit [31:0] o2);
    bit [95:0] w;
    bit [15:0] base;
    base = vm.pc;
    w = {o2, o1, 8'($urandom()), 16'($urandom()), op};
    if (32'(base) + InstrBytes > 32'd65536) return;
    for (int i = 0; i < InstrBytes; i++) send(FUNC_WRITE, base + 16'(i), w[8*i +: 8]);
  endtask

  task automatic exec_here();
    vm.data_needs(need_q);
    foreach (need_q[i]) send(FUNC_WRITE, need_q[i][15:0], 8'($urandom()));
    send(FUNC_EXEC, 16'($urandom()), 8'($urandom()));
  endtask

  task automatic run_op(bit [7:0] op, bit [31:0] o1, bit [31:0] o2);
    put_instr(op, o1, o2);
    exec_here();
    if (vm.st != ST_RUN) send(FUNC_RESTART, 16'($urandom()), 8'($urandom()));
  endtask

  function automatic bit [31:0] pick_operand();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return $urandom_range(0, 9);
    if (r < 73) return $urandom_range(10, 40);
    if (r < 92) return $urandom_range(0, 16'hFFFF);
    return $urandom();
  endfunction

  task automatic random_item();
    int unsigned r;
    bit [7:0]    op;
    r = $urandom_range(0, 99);
    if (vm.st != ST_RUN || r < 4) begin
      send(FUNC_RESTART, 16'($urandom()), 8'($urandom()));
    end else if (r < 14 || vm.known_q.size() == 0) begin
      send(FUNC_WRITE, 16'($urandom()), 8'($urandom()));
    end else if (r < 24) begin
      send(FUNC_READ, vm.known_q[$urandom_range(0, vm.known_q.size() - 1)][15:0],
           8'($urandom()));
    end else begin
      if (!vm.instr_ready() || $urandom_range(0, 99) < 30) begin
        op = ($urandom_range(0, 99) < 93) ? 8'($urandom_range(0, 24))
                                          : 8'($urandom_range(25, 255));
        put_instr(op, pick_operand(), pick_operand());
      end
      exec_here();
    end
  endtask

  initial begin
    bit [15:0] starts[4];
    starts = '{16'h0000, 16'hFFFF, 16'hFFF4, 16'($urandom())};
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: opcodes, traps, faults and arithmetic corner cases
    set_start(16'h0000);
    send(FUNC_EXEC, 16'h0000, 8'h00);
    send(FUNC_RESTART, 16'hFFFF, 8'hFF);
    run_op(8'(OP_LDA), 1, 32'hFFFF_FFFF);
    run_op(8'(OP_ADI), 0, 32'h8000_0000);
    run_op(8'(OP_DIV), 0, 1);
    run_op(8'(OP_TRP), TrapInt, 0);
    run_op(8'(OP_TRP), TrapChar, 0);
    run_op(8'(OP_TRP), 5, 0);
    run_op(8'(OP_DIV), 0, 6);
    run_op(8'(OP_CMP), 2, 0);
    run_op(8'(OP_AND), 2, 1);
    run_op(8'(OP_OR), 3, 6);
    run_op(8'(OP_STR), 0, 32'h0000_0200);
    run_op(8'(OP_LDA), 4, 32'h0000_0300);
    run_op(8'(OP_STRI), 1, 4);
    run_op(8'(OP_LDRI), 5, 4);
    run_op(8'(OP_LDB), 6, 32'h0000_0201);
    run_op(8'(OP_STRI), 0, 1);
    run_op(8'(OP_JMP), 32'h0001_0000, 0);
    run_op(8'(OP_MOV), 10, 0);
    run_op(8'hFF, 0, 0);
    run_op(8'(OP_TRP), TrapHalt, 0);
    send(FUNC_READ, 16'h0200, 8'h00);

    // Random phases with different start addresses and handshake pressure
    for (int ph = 0; ph < 4; ph++) begin
      wait_idle();
      set_start(starts[ph]);
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 77; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 77; end
        default: begin idle_pct = 17; stall_pct = 17; end
      endcase
      send(FUNC_RESTART, 16'($urandom()), 8'($urandom()));
      if (ph == 2) run_op(8'(OP_ADI), 0, 1);
      while (n_items < 300 + 290 * (ph + 1)) random_item();
    end

    wait_idle();
    $display("%0d transactions in, %0d results checked: %0d instructions executed,",
             n_items, vm.n_checked, vm.n_exec);
    $display("%0d print traps, %0d faults", vm.n_traps, vm.n_faults);
    if (vm.errors == 0) $display("** byte_memory_register_vm_core: PASSED **");
    else $display("** byte_memory_register_vm_core: FAILED **");
    $finish;
  end
endmodule

/* filelist.f */
+incdir+hdl
hdl/bmvm_pkg.sv
hdl/bmvm_div.sv
hdl/bmvm_mem.sv
hdl/byte_memory_register_vm_core.sv
verif/tb_top.sv
